// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define SFL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled valid word holds its payload into the next cycle.
`define SFL_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, sig, msg) \
  `SFL_ASSERT(lbl, clk, rst_n, (vld) && (stl) |=> (vld) && $stable(sig), msg)

`endif

// ===== sv/sfl_pkg.sv =====
// Types and constants shared across the stereo flanger modules.
`timescale 1ns / 1ps

package sfl_pkg;

  localparam int DELAY_DEPTH_DEF = 512;
  localparam int SAMPLE_W        = 16;
  localparam int FRAC_W          = 16;
  localparam int STEP_W          = 16;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd131;

  // Output queue: depth covers the frames in the pipeline plus one word.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       block_end;
  } sfl_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       block_end_out;
  } sfl_out_t;

  // Per-frame lane control from the sweep controller.
  typedef struct packed {
    logic              wr_en;
    logic              ok1;
    logic              ok2;
    logic [FRAC_W-1:0] frac;
  } sfl_ctl_t;

endpackage

// ===== sv/stereo_flanger_unit.sv =====
// Top level of the stereo flanger: sweep control, two channel lanes, merge.
`timescale 1ns / 1ps

// Channel | Direction | Handshake                    | Word
// in      | input     | in_valid_i / in_stall_o      | sfl_in_t  (left, right, block end)
// out     | output    | out_valid_o / out_stall_i    | sfl_out_t (left, right, block end)
// cfg     | input     | cfg_we_i, no wait            | cfg_wdata_i (sweep step)
//
// Sustained rate is one frame per cycle while out_stall_i stays low: two read ports and one
// write port per lane bank read both taps and write the dry sample at the accepting edge.
// A frame passes the read, multiply and queue registers between accept and out_valid_o.
// Reset clears control state only; a fill flag masks never-written entries to zero.
// A four-word output queue absorbs downstream stalls; in_stall_o rises only when
// four frames are in flight or queued.

module stereo_flanger_unit import sfl_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sfl_in_t           in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfl_out_t          out_word_o,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(DELAY_DEPTH);

  logic                       acc;
  logic [AW-1:0]              rd_addr1, rd_addr2, wr_addr;
  sfl_ctl_t                   ctl;
  logic signed [SAMPLE_W-1:0] left_res, right_res;

  // Take a word whenever it is offered and the queue has room.
  assign acc = in_valid_i && !in_stall_o;

  // Shared sweep and write index: both lanes tap the same offsets.
  sfl_ctrl #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rd_addr1_o (rd_addr1),
    .rd_addr2_o (rd_addr2),
    .wr_addr_o  (wr_addr),
    .ctl_o      (ctl)
  );

  // Left lane keeps its own delay bank of left samples.
  sfl_lane #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_lane_left (
    .clk_i     (clk_i),
    .rd_addr1_i(rd_addr1),
    .rd_addr2_i(rd_addr2),
    .wr_addr_i (wr_addr),
    .ctl_i     (ctl),
    .dry_i     (in_word_i.left_in),
    .res_o     (left_res)
  );

  // Right lane keeps its own delay bank of right samples.
  sfl_lane #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_lane_right (
    .clk_i     (clk_i),
    .rd_addr1_i(rd_addr1),
    .rd_addr2_i(rd_addr2),
    .wr_addr_i (wr_addr),
    .ctl_i     (ctl),
    .dry_i     (in_word_i.right_in),
    .res_o     (right_res)
  );

  // Pair the lane results with the block marker and queue the word.
  sfl_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .block_end_i(in_word_i.block_end),
    .left_i     (left_res),
    .right_i    (right_res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o),
    .in_stall_o (in_stall_o)
  );

endmodule

// ===== sv/sfl_ctrl.sv =====
// Write index, fill flag, sweep position and tap address generation.
`timescale 1ns / 1ps

module sfl_ctrl import sfl_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           acc_i,
  input  logic                           cfg_we_i,
  input  logic [STEP_W-1:0]              cfg_wdata_i,
  output logic [$clog2(DELAY_DEPTH)-1:0] rd_addr1_o,
  output logic [$clog2(DELAY_DEPTH)-1:0] rd_addr2_o,
  output logic [$clog2(DELAY_DEPTH)-1:0] wr_addr_o,
  output sfl_ctl_t                       ctl_o
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int OW = $clog2(DELAY_DEPTH + 2);
  localparam int PW = OW + FRAC_W + 1;
  localparam int SW = OW + 1;
  localparam logic [PW-1:0] POS_HALF = {1'b0, OW'(DELAY_DEPTH / 2), {FRAC_W{1'b0}}};
  localparam logic [PW-1:0] POS_TOP  = {1'b0, OW'(DELAY_DEPTH), {FRAC_W{1'b0}}};
  localparam logic [SW-1:0] DEPTH_S  = SW'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST     = AW'(DELAY_DEPTH - 1);

  logic [AW-1:0]     wi_q, wi_d;
  logic              full_q, full_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              fall_q, fall_d;
  logic [STEP_W-1:0] step_q;

  logic              neg;
  logic [OW-1:0]     offs;
  logic [FRAC_W-1:0] frac;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     p1w;
  logic [AW-1:0]     p1, p2;
  logic [PW-1:0]     step_ext, pos_mv;

  always_comb begin
    neg  = pos_q[PW-1];
    // Clamp a negative sweep to the entry at the write index.
    offs = neg ? '0 : pos_q[PW-2:FRAC_W];
    frac = neg ? '0 : pos_q[FRAC_W-1:0];
    sum  = SW'(wi_q) + SW'(offs);
    p1w  = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
    p1   = p1w[AW-1:0];
    p2   = (p1 == LAST) ? '0 : (p1 + 1'b1);

    step_ext = {{(PW-STEP_W){1'b0}}, step_q};
    pos_mv   = fall_q ? (pos_q - step_ext) : (pos_q + step_ext);

    wi_d   = wi_q;
    full_d = full_q;
    pos_d  = pos_q;
    fall_d = fall_q;
    if (acc_i) begin
      wi_d   = (wi_q == LAST) ? '0 : (wi_q + 1'b1);
      full_d = full_q | (wi_q == LAST);
      pos_d  = pos_mv;
      if (pos_mv[PW-1]) begin
        fall_d = 1'b0;
      end else if ($signed(pos_mv) > $signed(POS_TOP)) begin
        fall_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      full_q <= 1'b0;
      pos_q  <= POS_HALF;
      fall_q <= 1'b0;
      step_q <= STEP_RESET;
    end else begin
      wi_q   <= wi_d;
      full_q <= full_d;
      pos_q  <= pos_d;
      fall_q <= fall_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  assign rd_addr1_o = p1;
  assign rd_addr2_o = p2;
  assign wr_addr_o  = wi_q;
  // Before the first wrap only entries below the write index hold data.
  assign ctl_o.wr_en = acc_i;
  assign ctl_o.ok1   = full_q || (p1 < wi_q);
  assign ctl_o.ok2   = full_q || (p2 < wi_q);
  assign ctl_o.frac  = frac;

endmodule

// ===== sv/sfl_lane.sv =====
// One channel lane: delay bank, interpolating tap and saturating mix.
`timescale 1ns / 1ps

module sfl_lane import sfl_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic [$clog2(DELAY_DEPTH)-1:0] rd_addr1_i,
  input  logic [$clog2(DELAY_DEPTH)-1:0] rd_addr2_i,
  input  logic [$clog2(DELAY_DEPTH)-1:0] wr_addr_i,
  input  sfl_ctl_t                       ctl_i,
  input  logic signed [SAMPLE_W-1:0]     dry_i,
  output logic signed [SAMPLE_W-1:0]     res_o
);

  localparam int PRW = 2 * (SAMPLE_W + 1);

  logic [SAMPLE_W-1:0] mem_q [DELAY_DEPTH];

  // Read stage.
  logic [SAMPLE_W-1:0]        rd1_q, rd2_q;
  logic                       ok1_q, ok2_q;
  logic [FRAC_W-1:0]          frac_q;
  logic signed [SAMPLE_W-1:0] dry1_q;

  // Product stage.
  logic signed [PRW-1:0]      prod_q;
  logic signed [SAMPLE_W-1:0] s1b_q;
  logic signed [SAMPLE_W-1:0] dry2_q;

  logic signed [SAMPLE_W-1:0] s1, s2;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [FRAC_W:0]     fracs;
  logic signed [PRW-1:0]      prod;
  logic signed [PRW-1:0]      acc;
  logic signed [SAMPLE_W-1:0] tap;
  logic signed [SAMPLE_W:0]   mix;

  // Read old contents before this frame's write lands.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= dry_i;
    end
    rd1_q <= mem_q[rd_addr1_i];
    rd2_q <= mem_q[rd_addr2_i];
  end

  always_comb begin
    s1    = ok1_q ? $signed(rd1_q) : '0;
    s2    = ok2_q ? $signed(rd2_q) : '0;
    diff  = {s2[SAMPLE_W-1], s2} - {s1[SAMPLE_W-1], s1};
    fracs = $signed({1'b0, frac_q});
    prod  = diff * fracs;
  end

  always_ff @(posedge clk_i) begin
    ok1_q  <= ctl_i.ok1;
    ok2_q  <= ctl_i.ok2;
    frac_q <= ctl_i.frac;
    dry1_q <= dry_i;
    prod_q <= prod;
    s1b_q  <= s1;
    dry2_q <= dry1_q;
  end

  // s1*(1-f) + s2*f == s1 + (s2-s1)*f, rounded half up.
  always_comb begin
    acc = {{(PRW-SAMPLE_W-FRAC_W){s1b_q[SAMPLE_W-1]}}, s1b_q, {FRAC_W{1'b0}}}
          + prod_q + PRW'(32768);
    tap = acc[FRAC_W+SAMPLE_W-1:FRAC_W];
    mix = {dry2_q[SAMPLE_W-1], dry2_q} + {tap[SAMPLE_W-1], tap};
    if (mix[SAMPLE_W] != mix[SAMPLE_W-1]) begin
      res_o = mix[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      res_o = mix[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== sv/sfl_merge.sv =====
// Merge of lane results into output words and the output queue.
`timescale 1ns / 1ps

module sfl_merge import sfl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic                       block_end_i,
  input  logic signed [SAMPLE_W-1:0] left_i,
  input  logic signed [SAMPLE_W-1:0] right_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output sfl_out_t                   out_word_o,
  output logic                       in_stall_o
);

  localparam logic [OQ_CW-1:0] OQ_FULL = OQ_CW'(OQ_DEPTH);

  logic             v1_q, v2_q;
  logic             be1_q, be2_q;
  sfl_out_t         oq_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_q, rp_q;
  logic [OQ_CW-1:0] fcnt_q, icnt_q;
  logic             push, pop;
  sfl_out_t         word;

  always_comb begin
    word.left_out      = left_i;
    word.right_out     = right_i;
    word.block_end_out = be2_q;
    push = v2_q;
    pop  = out_valid_o && !out_stall_i;
  end

  always_ff @(posedge clk_i) begin
    be1_q <= block_end_i;
    be2_q <= be1_q;
    if (push) begin
      oq_q[wp_q] <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      wp_q   <= '0;
      rp_q   <= '0;
      fcnt_q <= '0;
      icnt_q <= '0;
    end else begin
      v1_q   <= acc_i;
      v2_q   <= v1_q;
      wp_q   <= wp_q + OQ_AW'(push);
      rp_q   <= rp_q + OQ_AW'(pop);
      fcnt_q <= fcnt_q + OQ_CW'(push) - OQ_CW'(pop);
      icnt_q <= icnt_q + OQ_CW'(acc_i) - OQ_CW'(pop);
    end
  end

  // Count every frame in flight so the queue can never overflow.
  assign in_stall_o  = (icnt_q == OQ_FULL);
  assign out_valid_o = (fcnt_q != '0);
  assign out_word_o  = oq_q[rp_q];

endmodule

// ===== sv/sfl_checker.sv =====
// Port-level checker for the stereo flanger and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfl_checker import sfl_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sfl_out_t out_word_o
);

  localparam logic [OQ_CW-1:0] PEND_MAX = OQ_CW'(OQ_DEPTH);

  logic             in_acc, out_acc;
  logic [OQ_CW-1:0] pend_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Frames accepted and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + OQ_CW'(in_acc) - OQ_CW'(out_acc);
    end
  end

  `SFL_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_word_o, "stalled output word changed")
  `SFL_ASSERT(a_no_orphan, clk_i, rst_ni, out_valid_o |-> (pend_q != '0), "output word with no frame pending")
  `SFL_ASSERT(a_full_stall, clk_i, rst_ni, (pend_q == PEND_MAX) |-> in_stall_o, "frame taken beyond queue room")
  `SFL_ASSERT(a_latency, clk_i, rst_ni, (in_acc && (pend_q == '0)) |-> ##3 out_valid_o, "idle frame not out in three cycles")

endmodule

bind stereo_flanger_unit sfl_checker u_sfl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

// ===== tb/sv/tb_stereo_flanger_unit.sv =====
// Testbench for stereo_flanger_unit: random and directed frames checked against a local model.
`timescale 1ns / 1ps

module tb_stereo_flanger_unit;
  import sfl_pkg::*;

  localparam int DEPTH      = DELAY_DEPTH_DEF;
  localparam int FRAC_ONE   = 1 << FRAC_W;
  localparam int IDLE_PCT   = 20;
  localparam int CYCLE_CAP  = 200000;
  localparam int TAIL_WAIT  = 8;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic              clk_i       = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  sfl_in_t           in_word     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  sfl_out_t          out_word;
  logic              cfg_we      = 1'b0;
  logic [STEP_W-1:0] cfg_wdata   = '0;

  // Frames waiting to be offered, and mixes predicted for accepted frames.
  sfl_in_t  frame_q[$];
  sfl_out_t mixes_due[$];

  // Local copy of the flanger state.
  logic [31:0]       delay_line [DEPTH];
  int                wr_ptr;
  int                sweep_pos;
  bit                sweep_down;
  logic [STEP_W-1:0] sweep_step;

  int err_cnt   = 0;
  int cycle_cnt = 0;
  bit steady    = 1'b0;  // suppress idling on both sides while set

  stereo_flanger_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Linear interpolation between two stored samples, rounded half up.
  function automatic logic signed [15:0] blend(logic signed [15:0] near_s,
                                               logic signed [15:0] far_s,
                                               int unsigned frac);
    longint acc;
    acc = longint'(near_s) * (longint'(FRAC_ONE) - longint'(frac))
        + longint'(far_s) * longint'(frac);
    return 16'((acc + 32768) >>> 16);
  endfunction

  // Dry plus tap, clipped to the Q1.15 range.
  function automatic logic signed [15:0] mix_sat(logic signed [15:0] dry,
                                                 logic signed [15:0] tap);
    int s;
    s = int'(dry) + int'(tap);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  // Advance the flanger model by one frame and return the expected mix.
  function automatic sfl_out_t flange_frame(sfl_in_t w);
    int unsigned offs;
    int unsigned frac;
    int          p1;
    int          p2;
    logic [31:0] e1;
    logic [31:0] e2;
    sfl_out_t    r;
    // Below zero the tap sits at the write pointer with no fraction.
    if (sweep_pos < 0) begin
      offs = 0;
      frac = 0;
    end else begin
      offs = sweep_pos >>> FRAC_W;
      frac = sweep_pos & (FRAC_ONE - 1);
    end
    // Above depth the integer part may reach DEPTH; the address wraps.
    p1 = (wr_ptr + offs) % DEPTH;
    p2 = (p1 + 1) % DEPTH;
    e1 = delay_line[p1];
    e2 = delay_line[p2];
    r.left_out      = mix_sat(w.left_in,  blend(e1[15:0],  e2[15:0],  frac));
    r.right_out     = mix_sat(w.right_in, blend(e1[31:16], e2[31:16], frac));
    r.block_end_out = w.block_end;
    // Write the dry frame only after both taps are read.
    delay_line[wr_ptr] = {w.right_in, w.left_in};
    wr_ptr = (wr_ptr + 1) % DEPTH;
    if (sweep_down) sweep_pos -= int'(sweep_step);
    else            sweep_pos += int'(sweep_step);
    // Set the direction, never toggle it.
    if (sweep_pos < 0)                     sweep_down = 1'b0;
    else if (sweep_pos > DEPTH * FRAC_ONE) sweep_down = 1'b1;
    return r;
  endfunction

  // Driver: predict on every accepted word, then offer the next one or idle.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        mixes_due.push_back(flange_frame(in_word));
      end
      // Hold a stalled word; otherwise load the next one or drop valid.
      if (!in_valid || !in_stall) begin
        if (frame_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_word  <= frame_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest predicted mix.
  always @(posedge clk_i) begin
    sfl_out_t exp_w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (mixes_due.size() == 0) begin
          $error("unexpected output word left_out=%0d right_out=%0d block_end_out=%0b",
                 out_word.left_out, out_word.right_out, out_word.block_end_out);
          err_cnt++;
        end else begin
          exp_w = mixes_due.pop_front();
          if (out_word.left_out !== exp_w.left_out) begin
            $error("left_out: expected %0d, got %0d", exp_w.left_out, out_word.left_out);
            err_cnt++;
          end
          if (out_word.right_out !== exp_w.right_out) begin
            $error("right_out: expected %0d, got %0d", exp_w.right_out, out_word.right_out);
            err_cnt++;
          end
          if (out_word.block_end_out !== exp_w.block_end_out) begin
            $error("block_end_out: expected %0b, got %0b",
                   exp_w.block_end_out, out_word.block_end_out);
            err_cnt++;
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("tb_stereo_flanger_unit: errors");
      $finish;
    end
  end

  // Pick a sample, biased toward the full-scale values.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_frame(logic [15:0] l, logic [15:0] r, logic e);
    sfl_in_t w;
    w.left_in   = l;
    w.right_in  = r;
    w.block_end = e;
    frame_q.push_back(w);
  endtask

  task automatic queue_frames(int n);
    for (int k = 0; k < n; k++) begin
      push_frame(pick_sample(), pick_sample(), 1'($urandom));
    end
  endtask

  // Block until every queued frame is accepted and every mix has come back.
  task automatic wait_drained();
    while (frame_q.size() != 0 || in_valid || mixes_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write the sweep step while the block is idle and mirror it in the model.
  task automatic write_step(logic [STEP_W-1:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    sweep_step  = v;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
  endtask

  initial begin
    // Mirror the reset state: empty line, pointer at zero, sweep at half depth.
    foreach (delay_line[i]) delay_line[i] = '0;
    wr_ptr     = 0;
    sweep_pos  = (DEPTH / 2) * FRAC_ONE;
    sweep_down = 1'b0;
    sweep_step = STEP_RESET;

    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    // Field extremes and alternating bit patterns at the reset step.
    push_frame(16'h0000, 16'h0000, 1'b0);
    push_frame(16'h7FFF, 16'h7FFF, 1'b1);
    push_frame(16'h8000, 16'h8000, 1'b0);
    push_frame(16'h7FFF, 16'h8000, 1'b1);
    push_frame(16'h8000, 16'h7FFF, 1'b0);
    push_frame(16'hFFFF, 16'h0001, 1'b1);
    push_frame(16'h0001, 16'hFFFF, 1'b0);
    push_frame(16'h5555, 16'hAAAA, 1'b1);
    push_frame(16'hAAAA, 16'h5555, 1'b0);
    push_frame(16'h8001, 16'h7FFE, 1'b1);
    push_frame(16'hFFFF, 16'hFFFF, 1'b1);
    push_frame(16'h0001, 16'h0001, 1'b0);
    queue_frames(12);

    // Largest step: the sweep climbs past depth (address wrap), turns, and
    // falls below zero (tap clamped to the write pointer) within this phase.
    write_step(16'hFFFF);
    queue_frames(800);

    // Smallest step: fine fractions near the turning point.
    write_step(16'h0001);
    queue_frames(150);

    // Random step between the extremes with both sides streaming back to back.
    write_step(16'($urandom_range(65534, 2)));
    steady = 1'b1;
    queue_frames(376);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_stereo_flanger_unit: clean");
    end else begin
      $display("tb_stereo_flanger_unit: errors");
    end
    $finish;
  end

endmodule
